### hw/rtl/psw_pkg.sv
// ----------------------------------------------------------------------------
// psw_pkg: shared definitions for the power supervisor watchdog
// Field layout of the stream words, command codes, reply and request codes.
// ----------------------------------------------------------------------------
package psw_pkg;

    // Field widths
    localparam int CNT_W    = 16;
    localparam int RST_W    = 8;
    localparam int CMD_W    = 8;
    localparam int AUX_W    = 2;
    localparam int VAL_W    = 16;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 2;
    localparam int RAIL_W   = 3;
    localparam int REQ_W    = 2;
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = 16;

    // Input word layout, lowest bit first
    localparam int IN_CMD_LO   = 0;
    localparam int IN_PWR_BIT  = IN_CMD_LO + CMD_W;
    localparam int IN_AUX_LO   = IN_PWR_BIT + 1;
    localparam int IN_VAL_LO   = IN_AUX_LO + AUX_W;
    localparam int N_READ      = 6;
    localparam int IN_USED_W   = IN_VAL_LO + N_READ * VAL_W;
    localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;
    localparam int IN_USER_W   = 1;

    // Output word layout, lowest bit first
    localparam int OUT_USED_W  = STAT_W + VAL_W + RAIL_W + REQ_W + 5;
    localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_USER_W  = KIND_W;

    // Item kinds
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALIVE      = 8'd0;
    localparam logic [CMD_W-1:0] CMD_OFF_FIRST  = 8'd1;
    localparam logic [CMD_W-1:0] CMD_OFF_LAST   = 8'd5;
    localparam logic [CMD_W-1:0] CMD_ON_FIRST   = 8'd6;
    localparam logic [CMD_W-1:0] CMD_ON_LAST    = 8'd10;
    localparam logic [CMD_W-1:0] CMD_READ_FIRST = 8'd11;
    localparam logic [CMD_W-1:0] CMD_READ_LAST  = 8'd16;

    // Readback channels, offset from the first read command
    localparam logic [2:0] RD_BATTERY_V = 3'd0;
    localparam logic [2:0] RD_SOLAR_V   = 3'd1;
    localparam logic [2:0] RD_INPUT_I   = 3'd2;
    localparam logic [2:0] RD_OUTPUT_I  = 3'd3;
    localparam logic [2:0] RD_EXTERNAL  = 3'd4;
    localparam logic [2:0] RD_BATTERY_T = 3'd5;

    // Reply kinds
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd2;

    // Reply status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_LOW_V   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNKNOWN = 2'd2;

    // Rail requests
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ON   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_OFF  = 2'd2;

    localparam logic [RAIL_W-1:0] RAIL_AUX_5V = 3'd5;

    // Aux rail states
    localparam logic [AUX_W-1:0] AUX_OFF = 2'd0;
    localparam logic [AUX_W-1:0] AUX_ON  = 2'd1;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_POKE_LIMIT  = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_RESET_LIMIT = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_BATT_THRESH = 2'd2;

    // Configuration reset values
    localparam logic [CNT_W-1:0] POKE_LIMIT_RST  = 16'd60;
    localparam logic [RST_W-1:0] RESET_LIMIT_RST = 8'd3;
    localparam logic [VAL_W-1:0] BATT_THRESH_RST = 16'd2048;

endpackage

### hw/rtl/power_supervisor_watchdog_core.sv
// ----------------------------------------------------------------------------
// power_supervisor_watchdog_core: host watchdog and power supervisor
// Counts timer ticks, resets and power-cycles the host, answers host commands.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one word per timer tick or host command; tuser[0] selects
//   the kind (0 tick, 1 command), tdata carries the command code, host power
//   flag, aux rail state and six analog readings. m_axis returns exactly one
//   word per input word: tuser holds the reply kind, tdata the reply and the
//   rail, reset and power orders. The cfg port writes poke_limit (0),
//   reset_limit (1) and battery_threshold (2); write only while idle.
//   A word in the input register is evaluated against the watchdog state as
//   it moves into the result register, and shows on m_axis from then on.
//   Throughput: one word per cycle while m_axis_tready is high; the state
//   update is two saturating increments and compares, done as the word
//   moves into the result register. Reset clears both stage valids, the
//   counters and the reboot flag and reloads the register defaults. When
//   m_axis_tready is low the result holds; the input register still takes
//   one more word, then s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module power_supervisor_watchdog_core
    import psw_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write port
    input  logic                    i_cfg_we,
    input  logic [CFG_A_W-1:0]      i_cfg_addr,
    input  logic [CFG_D_W-1:0]      i_cfg_wdata,
    // input words
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // tdata: command[7:0], host_powered[8], aux_rail_state[10:9],
    // battery_voltage[26:11], solar_voltage[42:27], input_current[58:43],
    // output_current[74:59], external_analog[90:75],
    // battery_temperature[106:91], zero fill[111:107]
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: op[0]
    input  logic [IN_USER_W-1:0]    s_axis_tuser,
    // result words
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // tdata: reply_status[1:0], reply_word[17:2], rail_index[20:18],
    // rail_request[22:21], host_reset[23], all_off[24], all_on[25],
    // watchdog_fired[26], rebooting[27], zero fill[31:28]
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,
    // tuser: reply_kind[1:0]
    output logic [OUT_USER_W-1:0]   m_axis_tuser
);

    // Configuration registers
    logic [CNT_W-1:0] r_poke_limit;
    logic [RST_W-1:0] r_reset_limit;
    logic [VAL_W-1:0] r_batt_thresh;

    // Watchdog state
    logic [CNT_W-1:0] r_contact_cnt, n_contact_cnt;
    logic [RST_W-1:0] r_reset_cnt, n_reset_cnt;
    logic             r_reboot, n_reboot;

    // Pipeline registers
    logic                  r_in_valid;
    logic [IN_DATA_W-1:0]  r_in_data;
    logic [IN_USER_W-1:0]  r_in_user;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    logic advance;
    logic in_take;

    // Fields of the held input word
    logic [CMD_W-1:0] f_cmd;
    logic             f_powered;
    logic [AUX_W-1:0] f_aux;
    logic [VAL_W-1:0] f_val [N_READ];

    // Result fields
    logic [KIND_W-1:0] n_kind;
    logic [STAT_W-1:0] n_status;
    logic [VAL_W-1:0]  n_word;
    logic [RAIL_W-1:0] n_rail;
    logic [REQ_W-1:0]  n_req;
    logic              n_host_reset;
    logic              n_all_off;
    logic              n_all_on;
    logic              n_fired;

    logic [CNT_W-1:0]  cnt_inc;
    logic [RST_W-1:0]  rst_inc;
    logic [CMD_W-1:0]  cmd_off_idx;
    logic [CMD_W-1:0]  cmd_on_idx;
    logic [CMD_W-1:0]  cmd_rd_idx;

    // Handshake: move the input word on when the result slot is free
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // Unpack the input word
    assign f_cmd     = r_in_data[IN_CMD_LO +: CMD_W];
    assign f_powered = r_in_data[IN_PWR_BIT];
    assign f_aux     = r_in_data[IN_AUX_LO +: AUX_W];

    for (genvar g = 0; g < N_READ; g++) begin : g_val
        assign f_val[g] = r_in_data[IN_VAL_LO + g * VAL_W +: VAL_W];
    end

    // Saturating increments and command offsets
    assign cnt_inc     = (r_contact_cnt == '1) ? r_contact_cnt : r_contact_cnt + 1'b1;
    assign rst_inc     = (r_reset_cnt == '1) ? r_reset_cnt : r_reset_cnt + 1'b1;
    assign cmd_off_idx = f_cmd - CMD_OFF_FIRST;
    assign cmd_on_idx  = f_cmd - CMD_ON_FIRST;
    assign cmd_rd_idx  = f_cmd - CMD_READ_FIRST;

    // Evaluate one word against the watchdog state
    always_comb begin
        n_kind        = KIND_NONE;
        n_status      = STAT_OK;
        n_word        = '0;
        n_rail        = '0;
        n_req         = REQ_NONE;
        n_host_reset  = 1'b0;
        n_all_off     = 1'b0;
        n_all_on      = 1'b0;
        n_fired       = 1'b0;
        n_contact_cnt = r_contact_cnt;
        n_reset_cnt   = r_reset_cnt;
        n_reboot      = r_reboot;

        if (r_in_user[0] == OP_COMMAND) begin
            // Host contact: answer and clear the watchdog
            n_contact_cnt = '0;
            if (f_cmd == CMD_ALIVE) begin
                n_kind = KIND_STATUS;
            end else if (f_cmd <= CMD_OFF_LAST) begin
                n_kind = KIND_STATUS;
                n_rail = cmd_off_idx[RAIL_W-1:0];
                n_req  = REQ_OFF;
            end else if (f_cmd <= CMD_ON_LAST) begin
                n_kind = KIND_STATUS;
                if (f_val[RD_BATTERY_V] > r_batt_thresh) begin
                    n_rail = cmd_on_idx[RAIL_W-1:0];
                    n_req  = REQ_ON;
                end else begin
                    n_status = STAT_LOW_V;
                end
            end else if (f_cmd <= CMD_READ_LAST) begin
                n_kind = KIND_DATA;
                case (cmd_rd_idx[2:0])
                    RD_BATTERY_V: n_word = f_val[RD_BATTERY_V];
                    RD_SOLAR_V:   n_word = f_val[RD_SOLAR_V];
                    RD_INPUT_I:   n_word = f_val[RD_INPUT_I];
                    RD_OUTPUT_I:  n_word = f_val[RD_OUTPUT_I];
                    RD_EXTERNAL:  n_word = f_val[RD_EXTERNAL];
                    RD_BATTERY_T: n_word = f_val[RD_BATTERY_T];
                    default:      n_word = '0;
                endcase
            end else begin
                n_kind   = KIND_STATUS;
                n_status = STAT_UNKNOWN;
            end
        end else begin
            // Timer tick: advance the watchdog, escalate when it expires
            if (f_powered && (cnt_inc > r_poke_limit)) begin
                n_host_reset  = 1'b1;
                n_fired       = 1'b1;
                n_contact_cnt = '0;
                if (rst_inc > r_reset_limit) begin
                    n_all_off   = 1'b1;
                    n_reset_cnt = '0;
                    n_reboot    = 1'b1;
                end else begin
                    n_reset_cnt = rst_inc;
                end
            end else begin
                n_contact_cnt = f_powered ? cnt_inc : '0;
                // Reboot check: request the aux rail off while it is on, restore power once it is down
                if (r_reboot) begin
                    if (f_aux == AUX_OFF) begin
                        n_all_on      = 1'b1;
                        n_contact_cnt = '0;
                        n_reset_cnt   = '0;
                        n_reboot      = 1'b0;
                    end else if (f_aux == AUX_ON) begin
                        n_rail = RAIL_AUX_5V;
                        n_req  = REQ_OFF;
                    end
                end
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poke_limit  <= POKE_LIMIT_RST;
            r_reset_limit <= RESET_LIMIT_RST;
            r_batt_thresh <= BATT_THRESH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_POKE_LIMIT:  r_poke_limit  <= i_cfg_wdata[CNT_W-1:0];
                CFG_RESET_LIMIT: r_reset_limit <= i_cfg_wdata[RST_W-1:0];
                CFG_BATT_THRESH: r_batt_thresh <= i_cfg_wdata[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Control state: stage valids, watchdog counters and reboot flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_contact_cnt <= '0;
            r_reset_cnt   <= '0;
            r_reboot      <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_contact_cnt <= n_contact_cnt;
                r_reset_cnt   <= n_reset_cnt;
                r_reboot      <= n_reboot;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= s_axis_tdata;
            r_in_user <= s_axis_tuser;
        end
        if (advance) begin
            r_out_user <= n_kind;
            r_out_data <= {{(OUT_DATA_W - OUT_USED_W){1'b0}}, n_reboot, n_fired,
                           n_all_on, n_all_off, n_host_reset, n_req, n_rail,
                           n_word, n_status};
        end
    end

    // Checks
    a_all_off_sets_reboot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[24]) |-> r_out_data[27])
        else $error("all_off without reboot flag");

    a_all_on_clears_reboot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[25]) |-> (!r_out_data[27] && !r_reboot))
        else $error("all_on with reboot still pending");

    a_no_rail_no_index : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data[22:21] == REQ_NONE)) |-> (r_out_data[20:18] == '0))
        else $error("rail index set without a request");

    a_state_holds_when_stalled : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_contact_cnt) && $stable(r_reset_cnt) && $stable(r_reboot)))
        else $error("watchdog state changed without a word");

endmodule
